[hdl/tcw_pkg.sv]
package tcw_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SET   = 2'd3
  } op_e;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7F;

  localparam int unsigned TAB_STEP = 8;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_stat_t;

endpackage

[hdl/tcw_screen_ram.sv]
module tcw_screen_ram #(
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [15:0]              wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [15:0]              rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tcw_engine.sv]
module tcw_engine #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [1:0]                          op_i,
  input  logic [7:0]                          symbol_i,
  input  logic [6:0]                          column_i,
  input  logic [4:0]                          row_i,
  input  logic [7:0]                          attr_i,
  output tcw_pkg::eng_stat_t                  stat_o,
  output tcw_pkg::res_t                       res_o,
  input  logic                                res_ready_i,
  output logic                                ram_we_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_waddr_o,
  output logic [15:0]                         ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_raddr_o,
  input  logic [15:0]                         ram_rdata_i
);

  localparam int unsigned CELLS       = COLUMNS * ROWS;
  localparam int unsigned CW          = $clog2(COLUMNS);
  localparam int unsigned RW          = $clog2(ROWS);
  localparam int unsigned AW          = $clog2(CELLS);
  localparam int unsigned SCROLL_LAST = CELLS - COLUMNS - 1;
  localparam int unsigned FILL_FIRST  = CELLS - COLUMNS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_FIN
  } state_e;

  state_e          state_q, state_d;
  tcw_pkg::op_e    op_q, op_d;
  logic [7:0]      sym_q, sym_d;
  logic [6:0]      col_in_q, col_in_d;
  logic [4:0]      row_in_q, row_in_d;
  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [7:0]      cell_char_q, cell_char_d;
  logic [7:0]      cell_attr_q, cell_attr_d;

  logic [CW:0]     col_w;
  logic [RW:0]     row_w;
  logic [CW-1:0]   clamp_col;
  logic [RW-1:0]   clamp_row;
  logic [AW-1:0]   cur_pos;
  logic [AW-1:0]   rd_pos;
  logic [15:0]     blank;

  assign clamp_col = (32'(col_in_q) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(col_in_q);
  assign clamp_row = (32'(row_in_q) >= ROWS) ? RW'(ROWS - 1) : RW'(row_in_q);
  assign cur_pos   = AW'(32'(row_q) * COLUMNS + 32'(col_q));
  assign rd_pos    = AW'(32'(clamp_row) * COLUMNS + 32'(clamp_col));
  assign blank     = {attr_i, tcw_pkg::CH_SPACE};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sym_d       = sym_q;
    col_in_d    = col_in_q;
    row_in_d    = row_in_q;
    col_d       = col_q;
    row_d       = row_q;
    idx_d       = idx_q;
    cell_char_d = cell_char_q;
    cell_attr_d = cell_attr_q;
    col_w       = {1'b0, col_q};
    row_w       = {1'b0, row_q};
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d     = tcw_pkg::op_e'(op_i);
          sym_d    = symbol_i;
          col_in_d = column_i;
          row_in_d = row_i;
          state_d  = ST_EXEC;
        end
      end

      ST_EXEC: begin
        cell_char_d = '0;
        cell_attr_d = '0;
        unique case (op_q)
          tcw_pkg::OP_WRITE: begin
            if (sym_q == tcw_pkg::CH_BS) begin
              if (col_q != '0) begin
                col_w = col_w - 1'b1;
              end else if (row_q != '0) begin
                col_w = (CW+1)'(COLUMNS - 1);
                row_w = row_w - 1'b1;
              end
            end else if (sym_q == tcw_pkg::CH_TAB) begin
              col_w = (col_w + (CW+1)'(tcw_pkg::TAB_STEP)) &
                      ~((CW+1)'(tcw_pkg::TAB_STEP - 1));
            end else if (sym_q == tcw_pkg::CH_CR) begin
              col_w = '0;
            end else if (sym_q == tcw_pkg::CH_LF) begin
              col_w = '0;
              row_w = row_w + 1'b1;
            end else if (sym_q >= tcw_pkg::CH_SPACE && sym_q <= tcw_pkg::CH_LAST) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = cur_pos;
              ram_wdata_o = {attr_i, sym_q};
              col_w       = col_w + 1'b1;
            end
            // wrap to the next line
            if (col_w >= (CW+1)'(COLUMNS)) begin
              col_w = '0;
              row_w = row_w + 1'b1;
            end
            // past the bottom: scroll, priming the first read of row one
            if (row_w >= (RW+1)'(ROWS)) begin
              row_w       = (RW+1)'(ROWS - 1);
              ram_re_o    = 1'b1;
              ram_raddr_o = AW'(COLUMNS);
              idx_d       = '0;
              state_d     = ST_SCROLL;
            end else begin
              state_d = ST_FIN;
            end
            col_d = col_w[CW-1:0];
            row_d = row_w[RW-1:0];
          end
          tcw_pkg::OP_READ: begin
            ram_re_o    = 1'b1;
            ram_raddr_o = rd_pos;
            state_d     = ST_READ;
          end
          tcw_pkg::OP_CLEAR: begin
            idx_d   = '0;
            state_d = ST_CLEAR;
          end
          tcw_pkg::OP_SET: begin
            col_d   = clamp_col;
            row_d   = clamp_row;
            state_d = ST_FIN;
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end

      ST_READ: begin
        cell_char_d = ram_rdata_i[7:0];
        cell_attr_d = ram_rdata_i[15:8];
        state_d     = ST_FIN;
      end

      ST_SCROLL: begin
        // write the cell one line below back here, read the next one ahead
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q;
        ram_wdata_o = ram_rdata_i;
        if (idx_q == AW'(SCROLL_LAST)) begin
          idx_d   = AW'(FILL_FIRST);
          state_d = ST_FILL;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = AW'(32'(idx_q) + COLUMNS + 1);
          idx_d       = idx_q + 1'b1;
        end
      end

      ST_FILL, ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q;
        ram_wdata_o = blank;
        if (idx_q == AW'(CELLS - 1)) begin
          state_d = ST_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_FIN: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      op_q        <= tcw_pkg::OP_WRITE;
      sym_q       <= '0;
      col_in_q    <= '0;
      row_in_q    <= '0;
      idx_q       <= '0;
      cell_char_q <= '0;
      cell_attr_q <= '0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      op_q        <= op_d;
      sym_q       <= sym_d;
      col_in_q    <= col_in_d;
      row_in_q    <= row_in_d;
      idx_q       <= idx_d;
      cell_char_q <= cell_char_d;
      cell_attr_q <= cell_attr_d;
    end
  end

  assign stat_o.idle      = (state_q == ST_IDLE);
  assign stat_o.res_valid = (state_q == ST_FIN);

  assign res_o.cursor_column = 7'(32'(col_q));
  assign res_o.cursor_row    = 5'(32'(row_q));
  assign res_o.cursor_offset = 11'(32'(row_q) * COLUMNS + 32'(col_q));
  assign res_o.cell_char     = cell_char_q;
  assign res_o.cell_attr     = cell_attr_q;

endmodule

[hdl/text_console_writer.sv]
// Sequence: a cursor set and most bytes pass through the exec and finish states; a cell read adds
// a RAM read state, a clear writes all COLUMNS*ROWS cells, and a byte that scrolls copies
// (ROWS-1)*COLUMNS cells up one row, then blanks the last row; the cell RAM's single write
// port paces clears and scrolls. One item in work at a time; the next transaction is taken
// once the engine is idle, while the previous result may still sit in the output reg.
// Reset: cursor to origin, attribute 0x07; cell contents are undefined until a clear.
module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  symbol_i,
  input  logic [6:0]  column_i,
  input  logic [4:0]  row_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  cursor_column_o,
  output logic [4:0]  cursor_row_o,
  output logic [10:0] cursor_offset_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic [7:0]         attr_q, attr_d;
  logic               out_valid_q, out_valid_d;
  tcw_pkg::res_t      out_q, out_d;
  tcw_pkg::res_t      res;
  tcw_pkg::eng_stat_t stat;
  logic               res_ready;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [15:0]        ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [15:0]        ram_rdata;

  assign in_ready_o = stat.idle;
  assign res_ready  = !out_valid_q || out_ready_i;

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && in_ready_o),
    .op_i        (op_i),
    .symbol_i    (symbol_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .attr_i      (attr_q),
    .stat_o      (stat),
    .res_o       (res),
    .res_ready_i (res_ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tcw_screen_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    attr_d      = attr_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cfg_we_i) begin
      attr_d = cfg_wdata_i;
    end
    if (stat.res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= tcw_pkg::ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      attr_q      <= attr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_column_o = out_q.cursor_column;
  assign cursor_row_o    = out_q.cursor_row;
  assign cursor_offset_o = out_q.cursor_offset;
  assign cell_char_o     = out_q.cell_char;
  assign cell_attr_o     = out_q.cell_attr;

endmodule

[hdl/tcw_checker.sv]
module tcw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [6:0]  cursor_column_o,
  input logic [4:0]  cursor_row_o,
  input logic [10:0] cursor_offset_o,
  input logic [7:0]  cell_char_o,
  input logic [7:0]  cell_attr_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(cursor_column_o) &&
      $stable(cursor_row_o) && $stable(cursor_offset_o) && $stable(cell_char_o) &&
      $stable(cell_attr_o)))
    else $error("result changed while stalled");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction taken while busy");

  // cursor stays on screen and offset matches it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (COLUMNS <= 128) && (ROWS <= 32)) |->
      ((32'(cursor_column_o) < COLUMNS) && (32'(cursor_row_o) < ROWS) &&
       (cursor_offset_o == 11'(32'(cursor_row_o) * COLUMNS + 32'(cursor_column_o)))))
    else $error("cursor off screen or offset mismatch");

  // no result pending right out of reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);
